@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the path-cost block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GMCP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define GMCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GMCP_ASSERT(label, clk, rstn, prop, msg)
`define GMCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/gmcp_pkg.sv @@
`timescale 1ns / 1ps
package gmcp_pkg;

    // Grid geometry and data widths.
    localparam int MAX_COLS   = 1024;
    localparam int ROW_LIMIT  = 1024;
    localparam int COST_WIDTH = 16;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(ROW_LIMIT);
    localparam int COL_EFF_W  = COL_W + 1;
    localparam int ROW_EFF_W  = ROW_W + 1;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 28;
    localparam int OUT_W      = 27;
    localparam int S_TDATA_W  = ((COST_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // Result queue.
    localparam int QDEPTH = 3;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1
    } cfg_index_t;

    // Cell in flight between the index stage and the sum stage.
    typedef struct packed {
        logic                         valid;
        logic signed [COST_WIDTH-1:0] cost;
        logic [COL_W-1:0]             addr;
        logic                         first_row;
        logic                         first_col;
        logic                         last;
    } cell_t;

endpackage

@@ hw/rtl/gmcp_row_mem.sv @@
`timescale 1ns / 1ps
module gmcp_row_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [gmcp_pkg::COL_W-1:0] wr_addr,
    input  gmcp_pkg::sum_t            wr_data,
    input  logic                      rd_en,
    input  logic [gmcp_pkg::COL_W-1:0] rd_addr,
    output gmcp_pkg::sum_t            rd_data
);
    import gmcp_pkg::*;

    logic [SUM_W-1:0] mem [MAX_COLS];
    sum_t rd_data_reg;

    // Previous row's path sums, one entry per column.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= sum_t'(mem[rd_addr]);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/gmcp_ctrl.sv @@
`timescale 1ns / 1ps
module gmcp_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gmcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmcp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_acc,
    input  logic signed [gmcp_pkg::COST_WIDTH-1:0] s_cost,
    output logic [gmcp_pkg::COL_W-1:0]      rd_addr,
    output gmcp_pkg::cell_t                 st1
);
    import gmcp_pkg::*;

    logic [CFG_W-1:0]     num_rows_reg;
    logic [CFG_W-1:0]     num_cols_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    cell_t                st1_reg;
    logic [COL_EFF_W-1:0] eff_cols;
    logic [ROW_EFF_W-1:0] eff_rows;
    logic                 last_col;
    logic                 last_row;

    assign cfg_ready = 1'b1;

    // Zero counts as one, oversized values clamp to the maximum.
    always_comb begin
        if (num_cols_reg == '0) begin
            eff_cols = COL_EFF_W'(1);
        end else if (32'(num_cols_reg) > 32'(MAX_COLS)) begin
            eff_cols = COL_EFF_W'(MAX_COLS);
        end else begin
            eff_cols = COL_EFF_W'(num_cols_reg);
        end
        if (num_rows_reg == '0) begin
            eff_rows = ROW_EFF_W'(1);
        end else if (32'(num_rows_reg) > 32'(ROW_LIMIT)) begin
            eff_rows = ROW_EFF_W'(ROW_LIMIT);
        end else begin
            eff_rows = ROW_EFF_W'(num_rows_reg);
        end
    end

    assign last_col = (COL_EFF_W'(col_reg) + COL_EFF_W'(1)) >= eff_cols;
    assign last_row = (ROW_EFF_W'(row_reg) + ROW_EFF_W'(1)) >= eff_rows;
    assign rd_addr  = col_reg;

    // Registers, grid position and the cell handed to the sum stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            st1_reg      <= '0;
        end else begin
            st1_reg.valid <= s_acc;
            if (s_acc) begin
                st1_reg.cost      <= s_cost;
                st1_reg.addr      <= col_reg;
                st1_reg.first_row <= (row_reg == '0);
                st1_reg.first_col <= (col_reg == '0);
                st1_reg.last      <= last_row && last_col;
            end
            if (cfg_valid) begin
                case (cfg_index_t'(cfg_index))
                    CFG_NUM_ROWS: begin
                        num_rows_reg <= cfg_data;
                        col_reg      <= '0;
                        row_reg      <= '0;
                    end
                    CFG_NUM_COLS: begin
                        num_cols_reg <= cfg_data;
                        col_reg      <= '0;
                        row_reg      <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (s_acc) begin
                if (last_col && last_row) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (last_col) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    assign st1 = st1_reg;

endmodule

@@ hw/rtl/gmcp_sum_stage.sv @@
`timescale 1ns / 1ps
module gmcp_sum_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_acc,
    input  logic [gmcp_pkg::COL_W-1:0]   rd_addr,
    input  gmcp_pkg::cell_t              st1,
    input  gmcp_pkg::sum_t               rd_data,
    output logic                         wr_en,
    output logic [gmcp_pkg::COL_W-1:0]   wr_addr,
    output gmcp_pkg::sum_t               wr_data,
    output logic                         push,
    output logic [gmcp_pkg::OUT_W-1:0]   push_data
);
    import gmcp_pkg::*;

    sum_t left_sum_reg;
    sum_t diag_sum_reg;
    logic fwd_hit_reg;
    sum_t fwd_data_reg;
    sum_t up;
    sum_t cost_ext;
    sum_t min_du;
    sum_t min_all;
    sum_t sum;

    // A read issued while the same entry is written returns the old word,
    // so the written sum is forwarded instead (single-column grids).
    assign up       = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign cost_ext = sum_t'(st1.cost);
    assign min_du   = (diag_sum_reg < up) ? diag_sum_reg : up;
    assign min_all  = (min_du < left_sum_reg) ? min_du : left_sum_reg;

    // Path sum of the current cell.
    always_comb begin
        if (st1.first_row && st1.first_col) begin
            sum = cost_ext;
        end else if (st1.first_row) begin
            sum = left_sum_reg + cost_ext;
        end else if (st1.first_col) begin
            sum = up + cost_ext;
        end else begin
            sum = cost_ext + min_all;
        end
    end

    // Left and diagonal neighbors, and the forwarding capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_sum_reg <= '0;
            diag_sum_reg <= '0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (st1.valid) begin
                left_sum_reg <= sum;
                diag_sum_reg <= st1.first_row ? sum_t'(0) : up;
            end
            if (s_acc) begin
                fwd_hit_reg <= st1.valid && (st1.addr == rd_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            fwd_data_reg <= sum;
        end
    end

    assign wr_en     = st1.valid;
    assign wr_addr   = st1.addr;
    assign wr_data   = sum;
    assign push      = st1.valid && st1.last;
    assign push_data = sum[OUT_W-1:0];

endmodule

@@ hw/rtl/gmcp_res_fifo.sv @@
`timescale 1ns / 1ps
module gmcp_res_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [gmcp_pkg::OUT_W-1:0]  push_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gmcp_pkg::OUT_W-1:0]  out_data,
    output logic [gmcp_pkg::QCNT_W-1:0] count
);
    import gmcp_pkg::*;

    logic [OUT_W-1:0]  entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              pop;

    assign pop = out_valid && out_ready;

    // Pointers wrap at the queue depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ hw/rtl/grid_min_cost_path.sv @@
// A grid's last cell is registered into the sum stage; its result is then queued.
// Throughput: one cell per cycle unless held off; the row store is read as a cell is
// accepted, and the left-neighbor add and three-way compare are combinational.
// Up to three results queue at the output before input transfers are held off.
// Reset: grid sizes return to 1 x 1, position and neighbor sums clear, queue empties;
// the row store is not cleared (row 0 writes every column in use before a later read).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grid_min_cost_path (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: [15:0] cell_cost
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gmcp_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [26:0] path_cost, [31:27] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gmcp_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gmcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gmcp_pkg::CFG_W-1:0]         cfg_data
);
    import gmcp_pkg::*;

    logic                  s_acc;
    logic [COL_W-1:0]      rd_addr;
    cell_t                 st1;
    sum_t                  rd_data;
    logic                  wr_en;
    logic [COL_W-1:0]      wr_addr;
    sum_t                  wr_data;
    logic                  push;
    logic [OUT_W-1:0]      push_data;
    logic [OUT_W-1:0]      fifo_data;
    logic [QCNT_W-1:0]     q_count;
    logic [QCNT_W:0]       q_claim;

    // Room for the cell in the sum stage plus one more possible result.
    assign q_claim  = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(st1.valid && st1.last);
    assign s_tready = q_claim <= (QCNT_W + 1)'(QDEPTH - 1);
    assign s_acc    = s_tvalid && s_tready;

    gmcp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_acc     (s_acc),
        .s_cost    (s_tdata[COST_WIDTH-1:0]),
        .rd_addr   (rd_addr),
        .st1       (st1)
    );

    gmcp_row_mem u_row_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gmcp_sum_stage u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_acc     (s_acc),
        .rd_addr   (rd_addr),
        .st1       (st1),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_data (push_data)
    );

    gmcp_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_data),
        .count     (q_count)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, fifo_data};

    // A grid's last cell always leaves a result waiting.
    `GMCP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, push, m_tvalid, "last cell left no result")
    // The result queue is never written while full.
    `GMCP_ASSERT(a_no_overflow, aclk, aresetn, !push || (q_count != QCNT_W'(QDEPTH)), "result queue overflow")
    // Every transfer reaches the sum stage in the next cycle.
    `GMCP_ASSERT_NEXT(a_stage_follows, aclk, aresetn, s_acc, st1.valid, "accepted cell missing in sum stage")

endmodule
